### hw/rtl/padf_pkg.sv
// shared types and constants for the per-address report deadband filter
// no dependencies; used by padf_cell and the top level
`timescale 1ns / 1ps

package padf_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 16;

    localparam int ADDR_W = 48;
    localparam int STR_W = 8;
    localparam int TIME_W = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_STRENGTH_DELTA = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TIME_MS = 1'b1;

    localparam logic [STR_W-1:0] RESET_STRENGTH_DELTA = 8'd5;
    localparam logic [TIME_W-1:0] RESET_HOLD_TIME_MS = 32'd30000;

    typedef struct packed {
        logic [ADDR_W-1:0] device_address;
        logic signed [STR_W-1:0] signal_strength;
        logic [TIME_W-1:0] time_ms;
    } in_t;

    typedef struct packed {
        logic report;
        logic [ADDR_W-1:0] out_address;
        logic signed [STR_W-1:0] out_strength;
        logic was_known;
        logic evicted;
    } out_t;

    // sighting as it walks the chain of cells
    typedef struct packed {
        logic valid;
        in_t item;
        logic hit;
        logic report;
        logic free_found;
    } token_t;

    // table write broadcast to all cells
    typedef struct packed {
        logic en;
        in_t item;
    } wr_t;

endpackage

### hw/rtl/padf_cell.sv
// one table entry plus one stage of the sighting chain
// depends on padf_pkg
`timescale 1ns / 1ps

module padf_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic [padf_pkg::STR_W-1:0] strength_delta,
    input  logic [padf_pkg::TIME_W-1:0] hold_time_ms,
    input  padf_pkg::token_t tok_in,
    input  logic [IDX_W-1:0] hit_slot_in,
    input  logic [IDX_W-1:0] free_slot_in,
    output padf_pkg::token_t tok_out,
    output logic [IDX_W-1:0] hit_slot_out,
    output logic [IDX_W-1:0] free_slot_out,
    input  padf_pkg::wr_t wr,
    input  logic [IDX_W-1:0] wr_slot
);

    localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(INDEX);

    logic entry_valid_reg;
    logic [padf_pkg::ADDR_W-1:0] entry_address_reg;
    logic signed [padf_pkg::STR_W-1:0] entry_strength_reg;
    logic [padf_pkg::TIME_W-1:0] entry_time_reg;

    padf_pkg::token_t tok_reg;
    padf_pkg::token_t tok_next;
    logic [IDX_W-1:0] hit_slot_reg;
    logic [IDX_W-1:0] hit_slot_next;
    logic [IDX_W-1:0] free_slot_reg;
    logic [IDX_W-1:0] free_slot_next;

    logic match;
    logic [padf_pkg::STR_W:0] diff;
    logic [padf_pkg::STR_W-1:0] abs_diff;
    logic [padf_pkg::TIME_W-1:0] elapsed;
    logic quiet;
    logic write_me;

    assign match = entry_valid_reg
        && (entry_address_reg == tok_in.item.device_address);
    assign diff = {tok_in.item.signal_strength[padf_pkg::STR_W-1],
                   tok_in.item.signal_strength}
                - {entry_strength_reg[padf_pkg::STR_W-1], entry_strength_reg};
    assign abs_diff = diff[padf_pkg::STR_W] ? padf_pkg::STR_W'(-diff)
                                            : diff[padf_pkg::STR_W-1:0];
    assign elapsed = tok_in.item.time_ms - entry_time_reg;
    assign quiet = (abs_diff < strength_delta) && (elapsed < hold_time_ms);
    assign write_me = wr.en && (wr_slot == MY_SLOT);

    always_comb
    begin
        tok_next = tok_in;
        hit_slot_next = hit_slot_in;
        free_slot_next = free_slot_in;
        if (!tok_in.hit && match)
        begin
            tok_next.hit = 1'b1;
            tok_next.report = !quiet;
            hit_slot_next = MY_SLOT;
        end
        if (!tok_in.free_found && !entry_valid_reg)
        begin
            tok_next.free_found = 1'b1;
            free_slot_next = MY_SLOT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            entry_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                tok_reg <= tok_next;
            end
            if (write_me)
            begin
                entry_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_slot_reg <= hit_slot_next;
            free_slot_reg <= free_slot_next;
        end
        if (write_me)
        begin
            entry_address_reg <= wr.item.device_address;
            entry_strength_reg <= wr.item.signal_strength;
            entry_time_reg <= wr.item.time_ms;
        end
    end

    assign tok_out = tok_reg;
    assign hit_slot_out = hit_slot_reg;
    assign free_slot_out = free_slot_reg;

endmodule

### hw/rtl/per_address_report_deadband_filter_unit.sv
// top level of the per-address report deadband filter
// depends on padf_pkg and padf_cell
`timescale 1ns / 1ps

// Each sighting walks a chain of TABLE_ENTRIES cells, one cell per cycle unless the chain is
// held by a stalled output; every cell holds one table entry and checks the address,
// strength deadband and hold time against it. When the sighting leaves the chain the result
// is registered and, if it is reported, the table is updated. One sighting is in the chain
// at a time, so a new one is taken only once the last has left the chain; the result may
// wait in the output register while the next sighting walks. The table starts empty after
// reset and needs no clearing pass.
module per_address_report_deadband_filter_unit #(
    parameter int TABLE_ENTRIES = padf_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  padf_pkg::in_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output padf_pkg::out_t out_data,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [padf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [padf_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

    logic [padf_pkg::STR_W-1:0] strength_delta_reg;
    logic [padf_pkg::TIME_W-1:0] hold_time_ms_reg;
    logic [IDX_W-1:0] victim_reg;
    logic [IDX_W-1:0] victim_next;
    logic busy_reg;
    logic out_valid_reg;
    padf_pkg::out_t out_data_reg;
    padf_pkg::out_t out_data_next;

    padf_pkg::token_t tok [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] hit_slot [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] free_slot [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] chain_valid;

    padf_pkg::token_t tok_exit;
    padf_pkg::wr_t wr;
    logic [IDX_W-1:0] wr_slot;
    logic adv;
    logic in_fire;
    logic exit_fire;
    logic final_report;

    assign cfg_ready = 1'b1;
    assign in_stall = busy_reg;
    assign in_fire = in_valid && !in_stall;

    assign tok_exit = tok[TABLE_ENTRIES];
    assign adv = !(tok_exit.valid && out_valid_reg && out_stall);
    assign exit_fire = tok_exit.valid && adv;

    always_comb
    begin
        tok[0] = '0;
        tok[0].valid = in_fire;
        tok[0].item = in_data;
        hit_slot[0] = '0;
        free_slot[0] = '0;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        padf_cell #(
            .IDX_W(IDX_W),
            .INDEX(i)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .adv(adv),
            .strength_delta(strength_delta_reg),
            .hold_time_ms(hold_time_ms_reg),
            .tok_in(tok[i]),
            .hit_slot_in(hit_slot[i]),
            .free_slot_in(free_slot[i]),
            .tok_out(tok[i+1]),
            .hit_slot_out(hit_slot[i+1]),
            .free_slot_out(free_slot[i+1]),
            .wr(wr),
            .wr_slot(wr_slot)
        );
        assign chain_valid[i] = tok[i+1].valid;
    end

    always_comb
    begin
        final_report = tok_exit.hit ? tok_exit.report : 1'b1;
        if (tok_exit.hit)
        begin
            wr_slot = hit_slot[TABLE_ENTRIES];
        end
        else if (tok_exit.free_found)
        begin
            wr_slot = free_slot[TABLE_ENTRIES];
        end
        else
        begin
            wr_slot = victim_reg;
        end
        wr.en = exit_fire && final_report;
        wr.item = tok_exit.item;

        victim_next = victim_reg;
        if (exit_fire && !tok_exit.hit && !tok_exit.free_found)
        begin
            victim_next = (victim_reg == LAST_SLOT) ? '0 : victim_reg + IDX_W'(1);
        end

        out_data_next.report = final_report;
        out_data_next.out_address = tok_exit.item.device_address;
        out_data_next.out_strength = tok_exit.item.signal_strength;
        out_data_next.was_known = tok_exit.hit;
        out_data_next.evicted = !tok_exit.hit && !tok_exit.free_found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_delta_reg <= padf_pkg::RESET_STRENGTH_DELTA;
            hold_time_ms_reg <= padf_pkg::RESET_HOLD_TIME_MS;
            victim_reg <= '0;
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    padf_pkg::CFG_STRENGTH_DELTA:
                    begin
                        strength_delta_reg <= cfg_data[padf_pkg::STR_W-1:0];
                    end
                    padf_pkg::CFG_HOLD_TIME_MS:
                    begin
                        hold_time_ms_reg <= cfg_data[padf_pkg::TIME_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            victim_reg <= victim_next;
            if (in_fire)
            begin
                busy_reg <= 1'b1;
            end
            else if (exit_fire)
            begin
                busy_reg <= 1'b0;
            end
            if (exit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exit_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

`ifndef SYNTHESIS
    a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one sighting in the chain");

    a_busy_tracks_chain: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (|chain_valid))
        else $error("busy flag out of step with the chain");

    a_exit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        exit_fire |=> out_valid_reg && !busy_reg)
        else $error("finished sighting did not reach the output register");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (exit_fire && tok_exit.hit) |=> !out_data_reg.evicted && out_data_reg.was_known)
        else $error("known address flagged as eviction");
`endif

endmodule
